// File: rtl/ilsr_pkg.sv
// Shared types, constants and helper functions for the light sensor reader.
// No dependencies; every other file of the block imports this package.

package ilsr_pkg;

   // Configuration register indexes and reset values.
   localparam int unsigned CsrIndexWidth = 3;
   localparam logic [CsrIndexWidth-1:0] CSR_DEVICE_ADDRESS      = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_MODE_COMMAND        = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_HALF_PERIOD_TICKS   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_CONVERSION_WAIT     = 3'd3;
   localparam int unsigned CsrDataWidth = 24;

   localparam logic [6:0]  RESET_DEVICE_ADDRESS  = 7'd35;
   localparam logic [7:0]  RESET_MODE_COMMAND    = 8'd16;
   localparam logic [15:0] RESET_HALF_PERIOD     = 16'd250;
   localparam logic [23:0] RESET_CONVERSION_WAIT = 24'd2500000;

   localparam logic [7:0] POWER_ON_OPCODE = 8'h01;

   // Sequencer program: phase 0 is idle, the last phase is the final stop hold.
   localparam logic [4:0] PH_IDLE  = 5'd0;
   localparam logic [4:0] PH_FIRST = 5'd1;
   localparam logic [4:0] PH_LAST  = 5'd23;

   // Byte sources of a transmit phase.
   localparam logic [1:0] SRC_ADDR_W = 2'd0;
   localparam logic [1:0] SRC_POWER  = 2'd1;
   localparam logic [1:0] SRC_MODE   = 2'd2;
   localparam logic [1:0] SRC_ADDR_R = 2'd3;

   // Line levels of a hold phase: bit 1 is SCL, bit 0 is SDA (1 = released).
   localparam logic [1:0] LINES_BOTH_HIGH = 2'b11;
   localparam logic [1:0] LINES_SCL_HIGH  = 2'b10;
   localparam logic [1:0] LINES_BOTH_LOW  = 2'b00;

   // Receive phase argument: acknowledge after the byte, or not.
   localparam logic [1:0] RECV_ACK  = 2'd0;
   localparam logic [1:0] RECV_NACK = 2'd1;

   // floor(raw * 40 / 3) = (raw * ceil(40 * 2^23 / 3)) >> 23 for 16-bit raw.
   localparam int unsigned LuxShift = 23;
   localparam logic [26:0] LUX_RECIP = 27'd111848107;

   typedef enum logic [4:0] {
      K_IDLE = 5'b00001,
      K_HOLD = 5'b00010,
      K_SEND = 5'b00100,
      K_RECV = 5'b01000,
      K_WAIT = 5'b10000
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [1:0] arg;
   } seg_type;

   typedef struct packed {
      logic [6:0]  device_address;
      logic [7:0]  mode_command;
      logic [15:0] half_period_ticks;
      logic [23:0] conversion_wait_ticks;
   } cfg_type;

   typedef struct packed {
      logic        scl_out;
      logic        sda_pull_low;
      logic        busy_res;
      logic        done_res;
      logic [15:0] raw_count;
      logic [19:0] lux_sixteenths;
      logic        nack_seen;
   } item_type;

   function automatic seg_type ilsr_prog(input logic [4:0] phase);
      seg_type s;
      unique case (phase)
         5'd1, 5'd8, 5'd16:   s = '{K_HOLD, LINES_BOTH_HIGH};
         5'd2, 5'd9, 5'd17:   s = '{K_HOLD, LINES_SCL_HIGH};
         5'd3, 5'd10:         s = '{K_SEND, SRC_ADDR_W};
         5'd4:                s = '{K_SEND, SRC_POWER};
         5'd5, 5'd12, 5'd21:  s = '{K_HOLD, LINES_BOTH_LOW};
         5'd6, 5'd13, 5'd22:  s = '{K_HOLD, LINES_SCL_HIGH};
         5'd7, 5'd14, 5'd23:  s = '{K_HOLD, LINES_BOTH_HIGH};
         5'd11:               s = '{K_SEND, SRC_MODE};
         5'd15:               s = '{K_WAIT, 2'd0};
         5'd18:               s = '{K_SEND, SRC_ADDR_R};
         5'd19:               s = '{K_RECV, RECV_ACK};
         5'd20:               s = '{K_RECV, RECV_NACK};
         default:             s = '{K_IDLE, 2'd0};
      endcase
      return s;
   endfunction

   function automatic logic [7:0] ilsr_byte_from(input logic [1:0] src,
                                                 input cfg_type cfg);
      logic [7:0] b;
      unique case (src)
         SRC_ADDR_W: b = {cfg.device_address, 1'b0};
         SRC_POWER:  b = POWER_ON_OPCODE;
         SRC_MODE:   b = cfg.mode_command;
         SRC_ADDR_R: b = {cfg.device_address, 1'b1};
         default:    b = POWER_ON_OPCODE;
      endcase
      return b;
   endfunction

   // SDA level (1 = released) for the low half of the current bit slot.
   function automatic logic ilsr_data_level(input kind_type kind,
                                            input logic [3:0] bit_count,
                                            input logic shift_msb,
                                            input logic arg0);
      logic level;
      if (bit_count < 4'd8) begin
         level = (kind == K_SEND) ? shift_msb : 1'b1;
      end else begin
         level = (kind == K_SEND) ? 1'b1 : arg0;
      end
      return level;
   endfunction

   function automatic logic [19:0] ilsr_lux(input logic [15:0] raw);
      logic [42:0] prod;
      prod = {27'd0, raw} * {16'd0, LUX_RECIP};
      return prod[LuxShift +: 20];
   endfunction

endpackage

// File: rtl/ilsr_seq.sv
// Bit-level I2C master sequencer: holds the bus state and computes one tick.
// Depends on ilsr_pkg for the phase program, byte sources and lux scaling.

module ilsr_seq
   import ilsr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     step,
   input  logic     start_request,
   input  logic     sda_in,
   input  cfg_type  cfg,
   output item_type result
);

   logic [4:0]  phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_ff, shift_in;
   logic [23:0] tick_ff, tick_in;
   logic [15:0] raw_ff, raw_in;
   logic [19:0] lux_ff, lux_in;
   logic        ack_missing_ff, ack_missing_in;
   logic [1:0]  line_ff, line_in;
   logic [7:0]  first_ff, first_in;

   seg_type     seg, nseg;
   logic [23:0] limit_raw, limit;
   logic        enter_en;
   logic [4:0]  enter_ph;
   logic        done;
   logic [7:0]  entry_byte;

   always_comb begin
      seg = ilsr_prog(phase_ff);
      limit_raw = (seg.kind == K_WAIT) ? cfg.conversion_wait_ticks
                                       : {8'd0, cfg.half_period_ticks};
      limit = (limit_raw == 24'd0) ? 24'd1 : limit_raw;

      phase_in       = phase_ff;
      bit_count_in   = bit_count_ff;
      shift_in       = shift_ff;
      tick_in        = tick_ff;
      raw_in         = raw_ff;
      lux_in         = lux_ff;
      ack_missing_in = ack_missing_ff;
      line_in        = line_ff;
      first_in       = first_ff;
      enter_en       = 1'b0;
      enter_ph       = PH_IDLE;
      done           = 1'b0;
      nseg           = '{K_IDLE, 2'd0};
      entry_byte     = 8'd0;

      priority if (seg.kind == K_IDLE) begin
         line_in = LINES_BOTH_HIGH;
         if (start_request) begin
            ack_missing_in = 1'b0;
            enter_en = 1'b1;
            enter_ph = PH_FIRST;
         end
      end else if (tick_ff < limit) begin
         tick_in = tick_ff + 24'd1;
      end else if (seg.kind == K_HOLD || seg.kind == K_WAIT) begin
         enter_en = 1'b1;
         if (phase_ff >= PH_LAST) begin
            // End of the final stop: latch the count, high byte first.
            raw_in = {first_ff, shift_ff};
            lux_in = ilsr_lux(raw_in);
            done = 1'b1;
            enter_ph = PH_IDLE;
         end else begin
            enter_ph = phase_ff + 5'd1;
         end
      end else if (!line_ff[1]) begin
         // Low half is over: raise SCL for the high half.
         line_in[1] = 1'b1;
         tick_in = 24'd1;
      end else begin
         // End of a high half: sample SDA while SCL is still high.
         if (bit_count_ff < 4'd8) begin
            shift_in = (seg.kind == K_SEND) ? {shift_ff[6:0], 1'b0}
                                            : {shift_ff[6:0], sda_in};
         end else if (seg.kind == K_SEND && sda_in) begin
            ack_missing_in = 1'b1;
         end
         bit_count_in = bit_count_ff + 4'd1;
         if (bit_count_ff == 4'd8) begin
            if (seg.kind == K_RECV && seg.arg == RECV_ACK) begin
               first_in = shift_in;
            end
            enter_en = 1'b1;
            enter_ph = phase_ff + 5'd1;
         end else begin
            line_in = {1'b0, ilsr_data_level(seg.kind, bit_count_in,
                                             shift_in[7], seg.arg[0])};
            tick_in = 24'd1;
         end
      end

      if (enter_en) begin
         nseg = ilsr_prog(enter_ph);
         phase_in = (nseg.kind == K_IDLE) ? PH_IDLE : enter_ph;
         tick_in = 24'd1;
         bit_count_in = 4'd0;
         entry_byte = ilsr_byte_from(nseg.arg, cfg);
         unique case (nseg.kind)
            K_HOLD: line_in = nseg.arg;
            K_SEND: begin
               shift_in = entry_byte;
               line_in = {1'b0, entry_byte[7]};
            end
            K_RECV: begin
               shift_in = 8'd0;
               line_in = LINES_SCL_HIGH ^ LINES_BOTH_HIGH;
            end
            default: line_in = LINES_BOTH_HIGH;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_count_ff   <= 4'd0;
         shift_ff       <= 8'd0;
         tick_ff        <= 24'd0;
         raw_ff         <= 16'd0;
         lux_ff         <= 20'd0;
         ack_missing_ff <= 1'b0;
         line_ff        <= LINES_BOTH_HIGH;
         first_ff       <= 8'd0;
      end else if (step) begin
         phase_ff       <= phase_in;
         bit_count_ff   <= bit_count_in;
         shift_ff       <= shift_in;
         tick_ff        <= tick_in;
         raw_ff         <= raw_in;
         lux_ff         <= lux_in;
         ack_missing_ff <= ack_missing_in;
         line_ff        <= line_in;
         first_ff       <= first_in;
      end
   end

   // The result word reflects the state after this tick.
   assign result.scl_out        = line_in[1];
   assign result.sda_pull_low   = ~line_in[0];
   assign result.busy_res       = (phase_in != PH_IDLE);
   assign result.done_res       = done;
   assign result.raw_count      = raw_in;
   assign result.lux_sixteenths = lux_in;
   assign result.nack_seen      = ack_missing_in;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_LAST)
      else $error("sequencer phase left the program");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= 4'd8)
      else $error("bit counter passed the acknowledge slot");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (step && done) |=> (phase_ff == PH_IDLE && lux_ff == ilsr_lux(raw_ff)))
      else $error("completed measurement did not return to idle with a consistent lux");

endmodule

// File: rtl/i2c_light_sensor_reader_top.sv
// Top level of the light sensor reader: configuration registers, sequencer
// and a two-entry result buffer. Depends on ilsr_pkg and ilsr_seq.
//
// Every accepted request word is one tick of the I2C bus sequencer and yields
// exactly one registered response word. A new word can be taken every cycle
// while req_stall is low; the response side holds an output register
// plus one skid entry, so a request is still taken while one response waits,
// and req_stall rises only when both entries are full. A measurement takes
// the number of ticks set by half_period_ticks and conversion_wait_ticks.
// The lux value comes from one constant multiply on the latched count.
// Configuration writes are always accepted (csr_ready is tied high) and are
// meant to happen while the block is idle; indexes past the last register
// are ignored.

module i2c_light_sensor_reader_top
   import ilsr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_start_request,
   input  logic                     req_sda_in,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_scl_out,
   output logic                     rsp_sda_pull_low,
   output logic                     rsp_busy_res,
   output logic                     rsp_done_res,
   output logic [15:0]              rsp_raw_count,
   output logic [19:0]              rsp_lux_sixteenths,
   output logic                     rsp_nack_seen,

   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   cfg_type  cfg_ff;
   item_type seq_result;
   item_type out_ff, out_in;
   item_type skid_ff, skid_in;
   logic     out_valid_ff, out_valid_in;
   logic     skid_valid_ff, skid_valid_in;
   logic     accept, drain;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address        <= RESET_DEVICE_ADDRESS;
         cfg_ff.mode_command          <= RESET_MODE_COMMAND;
         cfg_ff.half_period_ticks     <= RESET_HALF_PERIOD;
         cfg_ff.conversion_wait_ticks <= RESET_CONVERSION_WAIT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEVICE_ADDRESS:    cfg_ff.device_address <= csr_data[6:0];
            CSR_MODE_COMMAND:      cfg_ff.mode_command <= csr_data[7:0];
            CSR_HALF_PERIOD_TICKS: cfg_ff.half_period_ticks <= csr_data[15:0];
            CSR_CONVERSION_WAIT:   cfg_ff.conversion_wait_ticks <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign drain     = out_valid_ff && !rsp_stall;

   ilsr_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .step          (accept),
      .start_request (req_start_request),
      .sda_in        (req_sda_in),
      .cfg           (cfg_ff),
      .result        (seq_result)
   );

   // A fresh word goes to the output register when it is free or draining,
   // otherwise into the skid entry; the skid entry moves up when drained.
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff && !drain;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (drain) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || drain) begin
            out_in       = seq_result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = seq_result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_scl_out        = out_ff.scl_out;
   assign rsp_sda_pull_low   = out_ff.sda_pull_low;
   assign rsp_busy_res       = out_ff.busy_res;
   assign rsp_done_res       = out_ff.done_res;
   assign rsp_raw_count      = out_ff.raw_count;
   assign rsp_lux_sixteenths = out_ff.lux_sixteenths;
   assign rsp_nack_seen      = out_ff.nack_seen;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a word while the output register is empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && rsp_stall && accept))
      else $error("skid entry filled without a held output word");

   a_empty_pass: assert property (@(posedge clock) disable iff (reset)
      (accept && !out_valid_ff) |=> (out_valid_ff && !skid_valid_ff))
      else $error("word taken into an empty buffer did not appear at the output");

endmodule
